@@ rtl/core/clt_pkg.sv @@
package clt_pkg;

	localparam int CHAR_W  = 8;
	localparam int POS_W   = 8;
	localparam int COUNT_W = 7;

	localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
	localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;

	localparam logic [COUNT_W-1:0] MAX_ARGS_RST = 7'd64;

	// result tdata layout, lowest bit first
	localparam int OUT_POS_LSB   = 0;
	localparam int OUT_BEGIN_BIT = OUT_POS_LSB + POS_W;
	localparam int OUT_QUOTE_BIT = OUT_BEGIN_BIT + 1;
	localparam int OUT_CUT_BIT   = OUT_QUOTE_BIT + 1;
	localparam int OUT_CNT_LSB   = OUT_CUT_BIT + 1;
	localparam int OUT_ERR_BIT   = OUT_CNT_LSB + COUNT_W;
	localparam int OUT_USED_W    = OUT_ERR_BIT + 1;
	localparam int OUT_DATA_W    = 24;

	typedef logic [CHAR_W-1:0]     char_t;
	typedef logic [COUNT_W-1:0]    count_t;
	typedef logic [OUT_DATA_W-1:0] out_data_t;

	function automatic logic is_space(input char_t c);
		is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

@@ rtl/core/command_line_tokenizer.sv @@
// The result of a transfer is registered and shows in the next cycle.
// Throughput: one character per cycle while m_axis_tready does not hold a
// result; the only loop is the scan-mode and counter update.
// A result held by a low m_axis_tready stalls input; a new character is taken
// in the same cycle the held result drains.
// Reset (arst_n low, asynchronous): scan mode to spaces, counters to zero,
// max_args to 64, no result pending.
module command_line_tokenizer #(
	parameter int LINE_MAX = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  clt_pkg::count_t           cfg_data,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  clt_pkg::char_t            s_axis_tdata,  // [7:0] ch
	input  logic                      s_axis_tlast,  // line_end
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// [7:0] position, [8] arg_begins, [9] arg_quoted, [10] cut_here,
	// [17:11] arg_count, [18] parse_error, [23:19] zero
	output clt_pkg::out_data_t        m_axis_tdata,
	output logic                      m_axis_tlast   // line_done
);
	import clt_pkg::*;

	localparam int IdxLimInt = (LINE_MAX - 1 > 255) ? 255 : (LINE_MAX - 1);
	localparam logic [POS_W-1:0] IDX_LIM = IdxLimInt[POS_W-1:0];

	typedef enum logic [1:0] {
		MODE_SPACE  = 2'd0,
		MODE_BARE   = 2'd1,
		MODE_DQUOTE = 2'd2,
		MODE_SQUOTE = 2'd3
	} mode_t;

	mode_t             mode_q, mode_d;
	logic [POS_W-1:0]  idx_q;
	count_t            args_q, args_d;
	count_t            max_args_q;
	logic              out_valid_q;
	out_data_t         out_data_q;
	logic              out_last_q;

	logic take;
	logic live;
	logic sp;
	logic begins, quoted, cut, err;
	out_data_t res;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign take          = s_axis_tvalid && s_axis_tready;
	assign live          = args_q < max_args_q;
	assign sp            = is_space(s_axis_tdata);

	always_comb begin
		mode_d = mode_q;
		args_d = args_q;
		begins = 1'b0;
		quoted = 1'b0;
		cut    = 1'b0;
		err    = 1'b0;
		if (s_axis_tlast) begin
			err = live && (mode_q == MODE_DQUOTE || mode_q == MODE_SQUOTE);
		end else if (live) begin
			unique case (mode_q)
				MODE_SPACE: begin
					if (!sp) begin
						args_d = args_q + 1'b1;
						if (s_axis_tdata == CH_DQUOTE) begin
							quoted = 1'b1;
							mode_d = MODE_DQUOTE;
						end else if (s_axis_tdata == CH_SQUOTE) begin
							quoted = 1'b1;
							mode_d = MODE_SQUOTE;
						end else begin
							begins = 1'b1;
							mode_d = MODE_BARE;
						end
					end
				end
				MODE_BARE: begin
					if (sp) begin
						cut    = 1'b1;
						mode_d = MODE_SPACE;
					end
				end
				MODE_DQUOTE: begin
					if (s_axis_tdata == CH_DQUOTE) begin
						cut    = 1'b1;
						mode_d = MODE_SPACE;
					end
				end
				MODE_SQUOTE: begin
					if (s_axis_tdata == CH_SQUOTE) begin
						cut    = 1'b1;
						mode_d = MODE_SPACE;
					end
				end
				default: begin
					mode_d = MODE_SPACE;
				end
			endcase
		end
		res = '0;
		res[OUT_POS_LSB +: POS_W]   = idx_q;
		res[OUT_BEGIN_BIT]          = begins;
		res[OUT_QUOTE_BIT]          = quoted;
		res[OUT_CUT_BIT]            = cut;
		res[OUT_CNT_LSB +: COUNT_W] = args_d;
		res[OUT_ERR_BIT]            = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_SPACE;
			idx_q       <= '0;
			args_q      <= '0;
			max_args_q  <= MAX_ARGS_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_args_q <= cfg_data;
			end
			if (take) begin
				out_valid_q <= 1'b1;
				if (s_axis_tlast) begin
					mode_q <= MODE_SPACE;
					idx_q  <= '0;
					args_q <= '0;
				end else begin
					mode_q <= mode_d;
					args_q <= args_d;
					if (idx_q < IDX_LIM) begin
						idx_q <= idx_q + 1'b1;
					end
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q <= res;
			out_last_q <= s_axis_tlast;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

@@ rtl/core/clt_checker.sv @@
module clt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input clt_pkg::out_data_t m_axis_tdata,
	input logic               m_axis_tlast
);
	import clt_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[OUT_BEGIN_BIT] && m_axis_tdata[OUT_QUOTE_BIT]))
		else $error("bare and quoted start together");

	a_eol_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[OUT_BEGIN_BIT] &&
			!m_axis_tdata[OUT_QUOTE_BIT] && !m_axis_tdata[OUT_CUT_BIT])
		else $error("token flags on end of line");

	a_err_eol: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[OUT_ERR_BIT] |-> m_axis_tlast)
		else $error("parse error on a character result");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:OUT_USED_W] == '0)
		else $error("padding bits set");

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
